@@ sv/rlvb_pkg.sv @@
// ----------------------------------------------------------------------------
// rlvb_pkg: shared constants and helpers of the RNG LES viscosity bisection
// Fixed-point format, register indexes, saturating product and midpoint.
// ----------------------------------------------------------------------------
package rlvb_pkg;

  // fixed-point format: unsigned Q(64-FRAC_BITS).FRAC_BITS
  localparam int FRAC_BITS = 44;
  localparam int WORD_W    = 64;
  localparam int MAX_STEPS = 64;
  localparam int STEP_W    = 7;
  // highest bit the floor cube root of u * 2^(2*FRAC_BITS) can set
  localparam int CBRT_TOP  = (WORD_W + 2 * FRAC_BITS) / 3;
  localparam int BIT_W     = 6;

  // configuration register widths
  localparam int THR_W   = 20;
  localparam int SCALE_W = 27;
  localparam int TOL_W   = 41;
  localparam int CFG_W   = 41;
  localparam int IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_SCALE     = 2'd1;
  localparam logic [IDX_W-1:0] REG_TOLERANCE = 2'd2;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // sign of f: pos / neg flags, zero when neither is set
  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

  // product of two fixed-point values, shifted down and saturated
  function automatic logic [WORD_W-1:0] fx_sat(input logic [2*WORD_W-1:0] p);
    logic [WORD_W-1:0] r;
    if (p[2*WORD_W-1:WORD_W+FRAC_BITS] != '0) begin
      r = ALL_ONES;
    end else begin
      r = p[WORD_W+FRAC_BITS-1:FRAC_BITS];
    end
    return r;
  endfunction

  // floor((a+b)/2) without overflow
  function automatic logic [WORD_W-1:0] midpoint(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    return (a >> 1) + (b >> 1) + {{(WORD_W-1){1'b0}}, a[0] & b[0]};
  endfunction

  function automatic logic opposite(input sign_t a, input sign_t b);
    return (a.pos & b.neg) | (a.neg & b.pos);
  endfunction

endpackage

@@ sv/rlvb_mul.sv @@
// ----------------------------------------------------------------------------
// rlvb_mul: shared multi-word multiplier
// 128 x 64 bit product built from eight 32 x 32 partial products, one a cycle.
// ----------------------------------------------------------------------------
module rlvb_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [2*rlvb_pkg::WORD_W-1:0] op_a,
  input  logic [rlvb_pkg::WORD_W-1:0]   op_b,
  output logic                          done,
  output logic [3*rlvb_pkg::WORD_W-1:0] prod
);

  logic [2*rlvb_pkg::WORD_W-1:0] a_r;
  logic [rlvb_pkg::WORD_W-1:0]   b_r;
  logic [3*rlvb_pkg::WORD_W-1:0] acc;
  logic [2:0]                    cnt;
  logic                          run;
  logic [31:0]                   limb_a;
  logic [31:0]                   limb_b;
  logic [63:0]                   pp;
  logic [2:0]                    sh;

  // current partial product and its weight
  assign limb_a = a_r[cnt[2:1]*32 +: 32];
  assign limb_b = b_r[cnt[0]*32 +: 32];
  assign pp     = limb_a * limb_b;
  assign sh     = {1'b0, cnt[2:1]} + {2'b0, cnt[0]};
  assign prod   = acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= op_a;
      b_r <= op_b;
      acc <= '0;
    end else if (run) begin
      acc <= acc + ({128'b0, pp} << {sh, 5'b0});
    end
  end

endmodule

@@ sv/rlvb_div.sv @@
// ----------------------------------------------------------------------------
// rlvb_div: fixed-point restoring divider
// Quotient (num << FRAC_BITS) / den, one bit a cycle, saturating to all ones.
// ----------------------------------------------------------------------------
module rlvb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [rlvb_pkg::WORD_W-1:0] num,
  input  logic [rlvb_pkg::WORD_W-1:0] den,
  output logic                        done,
  output logic [rlvb_pkg::WORD_W-1:0] quo
);

  logic [rlvb_pkg::WORD_W-1:0] nh;
  logic [rlvb_pkg::WORD_W-1:0] nl;
  logic [rlvb_pkg::WORD_W-1:0] d_r;
  logic [rlvb_pkg::WORD_W-1:0] nh_init;
  logic [rlvb_pkg::WORD_W-1:0] nh2;
  logic [5:0]                  cnt;
  logic                        run;
  logic                        ge;

  assign nh_init = num >> (rlvb_pkg::WORD_W - rlvb_pkg::FRAC_BITS);
  assign nh2     = {nh[rlvb_pkg::WORD_W-2:0], nl[rlvb_pkg::WORD_W-1]};
  assign ge      = nh[rlvb_pkg::WORD_W-1] | (nh2 >= d_r);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= '0;
        if (den == '0 || nh_init >= den) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (go) begin
      nh  <= nh_init;
      nl  <= num << rlvb_pkg::FRAC_BITS;
      d_r <= den;
      quo <= (den == '0 || nh_init >= den) ? rlvb_pkg::ALL_ONES : '0;
    end else if (run) begin
      nh  <= ge ? nh2 - d_r : nh2;
      nl  <= nl << 1;
      quo <= {quo[rlvb_pkg::WORD_W-2:0], ge};
    end
  end

endmodule

@@ sv/rng_les_viscosity_bisection_unit.sv @@
// ----------------------------------------------------------------------------
// rng_les_viscosity_bisection_unit: effective viscosity by bisection
// Sequencer around one shared multiplier and one divider.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result, which appears with done for exactly one cycle and cannot
// be held off. Latency depends on the data. Every pass through the shared
// multiplier issues, forms eight 32 x 32 partial products and signals done;
// the divider issues, forms 64 quotient bits (none when it saturates) and
// signals done. Setup computes the upper bracket end, L^2 and L^3, then runs
// the loop test. Each evaluation of f passes through the multiplier for S*x,
// then the divider, then the bit-by-bit cube root, whose CBRT_TOP + 1 bits
// each need two passes through the multiplier, and a last multiplier pass
// for L times the root. The first bisection step evaluates f three times,
// each further step once, for at most 64 steps.
module rng_les_viscosity_bisection_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rlvb_pkg::WORD_W-1:0]   laminar_visc,
  input  logic [rlvb_pkg::WORD_W-1:0]   subgrid_visc,
  output logic                          busy,
  output logic                          done,
  output logic [rlvb_pkg::WORD_W-1:0]   effective_visc,
  output logic                          fallback,
  input  logic                          cfg_we,
  input  logic [rlvb_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [rlvb_pkg::CFG_W-1:0]    cfg_data
);

  localparam int W = rlvb_pkg::WORD_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_UP   = 4'd1;
  localparam logic [3:0] ST_L2   = 4'd2;
  localparam logic [3:0] ST_L3   = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_EQ   = 4'd5;
  localparam logic [3:0] ST_EDIV = 4'd6;
  localparam logic [3:0] ST_ESQ  = 4'd7;
  localparam logic [3:0] ST_ECU  = 4'd8;
  localparam logic [3:0] ST_EP   = 4'd9;
  localparam logic [3:0] ST_DEC  = 4'd10;

  // evaluation targets
  localparam logic [1:0] TGT_A = 2'd0;
  localparam logic [1:0] TGT_B = 2'd1;
  localparam logic [1:0] TGT_M = 2'd2;

  logic [rlvb_pkg::THR_W-1:0]   thr;
  logic [rlvb_pkg::SCALE_W-1:0] scale;
  logic [rlvb_pkg::TOL_W-1:0]   tol;

  logic [3:0]  state;
  logic        issued;
  logic [W-1:0] lam, sgs, l2, l3, a, b, x, q, u, y;
  logic [2*W-1:0] sq;
  logic [rlvb_pkg::BIT_W-1:0] bitpos;
  logic [1:0]  tgt;
  logic        ends_known;
  logic [rlvb_pkg::STEP_W-1:0] steps;
  rlvb_pkg::sign_t sa, sb, sc, sx;

  logic           mul_go, mul_done, div_go, div_done;
  logic [2*W-1:0] mul_a;
  logic [W-1:0]   mul_b;
  logic [3*W-1:0] mul_p;
  logic [W-1:0]   div_q;

  logic [W-1:0]   big, mid, width, cand, cq, r, p;
  logic [W:0]     usum;
  logic [3*W-1:0] target;

  // combinational helpers
  assign big    = (sgs > lam) ? sgs : lam;
  assign mid    = rlvb_pkg::midpoint(a, b);
  assign width  = (a > b) ? a - b : b - a;
  assign cand   = y | (W'(1) << bitpos);
  assign cq     = ({{(W-rlvb_pkg::THR_W){1'b0}}, thr} >=
                   (W'(1) << (W - rlvb_pkg::FRAC_BITS))) ? rlvb_pkg::ALL_ONES :
                  ({{(W-rlvb_pkg::THR_W){1'b0}}, thr} << rlvb_pkg::FRAC_BITS);
  assign r      = (div_q > cq) ? div_q - cq : '0;
  assign usum   = {1'b0, r} + {1'b0, W'(1) << rlvb_pkg::FRAC_BITS};
  assign target = {{(2*W){1'b0}}, u} << (2 * rlvb_pkg::FRAC_BITS);
  assign p      = rlvb_pkg::fx_sat(mul_p[2*W-1:0]);
  assign sx.pos = p > x;
  assign sx.neg = p < x;
  assign busy   = (state != ST_IDLE);

  // shared unit requests
  always_comb begin
    mul_go = 1'b0;
    div_go = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_UP: begin
        mul_go = !issued;
        mul_a  = {{W{1'b0}}, big};
        mul_b  = {{(W-rlvb_pkg::SCALE_W){1'b0}}, scale};
      end
      ST_L2: begin
        mul_go = !issued;
        mul_a  = {{W{1'b0}}, lam};
        mul_b  = lam;
      end
      ST_L3: begin
        mul_go = !issued;
        mul_a  = {{W{1'b0}}, l2};
        mul_b  = lam;
      end
      ST_EQ: begin
        mul_go = !issued;
        mul_a  = {{W{1'b0}}, sgs};
        mul_b  = x;
      end
      ST_EDIV: begin
        div_go = !issued;
      end
      ST_ESQ: begin
        mul_go = !issued;
        mul_a  = {{W{1'b0}}, cand};
        mul_b  = cand;
      end
      ST_ECU: begin
        mul_go = !issued;
        mul_a  = sq;
        mul_b  = cand;
      end
      ST_EP: begin
        mul_go = !issued;
        mul_a  = {{W{1'b0}}, lam};
        mul_b  = y;
      end
      default: begin
      end
    endcase
  end

  rlvb_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .op_a (mul_a),
    .op_b (mul_b),
    .done (mul_done),
    .prod (mul_p)
  );

  rlvb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (q),
    .den  (l3),
    .done (div_done),
    .quo  (div_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr   <= rlvb_pkg::THR_W'(100);
      scale <= rlvb_pkg::SCALE_W'(10000000);
      tol   <= rlvb_pkg::TOL_W'(1759);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rlvb_pkg::REG_THRESHOLD: thr   <= cfg_data[rlvb_pkg::THR_W-1:0];
        rlvb_pkg::REG_SCALE:     scale <= cfg_data[rlvb_pkg::SCALE_W-1:0];
        rlvb_pkg::REG_TOLERANCE: tol   <= cfg_data[rlvb_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (mul_go || div_go) begin
        issued <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            lam        <= laminar_visc;
            sgs        <= subgrid_visc;
            steps      <= '0;
            ends_known <= 1'b0;
            state      <= ST_UP;
          end
        end
        ST_UP: begin
          if (mul_done) begin
            issued <= 1'b0;
            a      <= lam;
            b      <= (mul_p[2*W-1:W] != '0) ? rlvb_pkg::ALL_ONES : mul_p[W-1:0];
            state  <= ST_L2;
          end
        end
        ST_L2: begin
          if (mul_done) begin
            issued <= 1'b0;
            l2     <= p;
            state  <= ST_L3;
          end
        end
        ST_L3: begin
          if (mul_done) begin
            issued <= 1'b0;
            l3     <= p;
            state  <= ST_CHK;
          end
        end
        // loop test, then start the evaluations this step needs
        ST_CHK: begin
          if (steps == rlvb_pkg::STEP_W'(rlvb_pkg::MAX_STEPS) ||
              width <= {{(W-rlvb_pkg::TOL_W){1'b0}}, tol}) begin
            effective_visc <= mid;
            fallback       <= 1'b0;
            done           <= 1'b1;
            state          <= ST_IDLE;
          end else if (!ends_known) begin
            x     <= a;
            tgt   <= TGT_A;
            state <= ST_EQ;
          end else begin
            x     <= mid;
            tgt   <= TGT_M;
            state <= ST_EQ;
          end
        end
        ST_EQ: begin
          if (mul_done) begin
            issued <= 1'b0;
            q      <= p;
            state  <= ST_EDIV;
          end
        end
        ST_EDIV: begin
          if (div_done) begin
            issued <= 1'b0;
            u      <= usum[W] ? rlvb_pkg::ALL_ONES : usum[W-1:0];
            y      <= '0;
            bitpos <= rlvb_pkg::BIT_W'(rlvb_pkg::CBRT_TOP);
            state  <= ST_ESQ;
          end
        end
        ST_ESQ: begin
          if (mul_done) begin
            issued <= 1'b0;
            sq     <= mul_p[2*W-1:0];
            state  <= ST_ECU;
          end
        end
        // keep the candidate bit when its cube stays within the target
        ST_ECU: begin
          if (mul_done) begin
            issued <= 1'b0;
            if (mul_p <= target) begin
              y <= cand;
            end
            if (bitpos == '0) begin
              state <= ST_EP;
            end else begin
              bitpos <= bitpos - rlvb_pkg::BIT_W'(1);
              state  <= ST_ESQ;
            end
          end
        end
        ST_EP: begin
          if (mul_done) begin
            issued <= 1'b0;
            unique case (tgt)
              TGT_A: begin
                sa    <= sx;
                x     <= b;
                tgt   <= TGT_B;
                state <= ST_EQ;
              end
              TGT_B: begin
                sb         <= sx;
                ends_known <= 1'b1;
                x          <= mid;
                tgt        <= TGT_M;
                state      <= ST_EQ;
              end
              default: begin
                sc    <= sx;
                state <= ST_DEC;
              end
            endcase
          end
        end
        // keep the half whose ends differ in sign, the a side first; else fall back to L
        ST_DEC: begin
          steps <= steps + rlvb_pkg::STEP_W'(1);
          priority if (rlvb_pkg::opposite(sa, sc)) begin
            b     <= x;
            sb    <= sc;
            state <= ST_CHK;
          end else if (rlvb_pkg::opposite(sb, sc)) begin
            a     <= x;
            sa    <= sc;
            state <= ST_CHK;
          end else begin
            effective_visc <= lam;
            fallback       <= 1'b1;
            done           <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/rlvb_checker.sv @@
// ----------------------------------------------------------------------------
// rlvb_checker: port-level checks of the bisection unit
// Start/busy/done sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
module rlvb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted transfer makes the unit busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted start");

  // the result strobe comes with the unit idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // the strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // busy only ends with a result
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result");

endmodule

bind rng_les_viscosity_bisection_unit rlvb_checker u_rlvb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

@@ dv/tb_rng_les_viscosity_bisection_unit.sv @@
// ----------------------------------------------------------------------------
// tb_rng_les_viscosity_bisection_unit: self-checking bench of the bisection unit
// Drives laminar/subgrid viscosity pairs through the command port. Writes
// every register across several settings, extremes included. Checks each
// result against an in-bench fixed-point bisection predictor.
// ----------------------------------------------------------------------------
module tb_rng_les_viscosity_bisection_unit;

  localparam logic [rlvb_pkg::IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, ignored
  localparam bit [63:0] ONES64 = '1;
  localparam bit [63:0] UNIT   = 64'd1 << rlvb_pkg::FRAC_BITS;

  // --------------------------------------------------------------------------
  // scoreboard: holds register copies, predicts and queues results, checks
  // --------------------------------------------------------------------------
  class visc_scoreboard;
    bit [63:0] thr_c;
    bit [63:0] scale;
    bit [63:0] tol;
    bit [64:0] expected_q[$];   // {fallback, effective_visc}
    int        mismatches;

    function void reset_regs();
      thr_c = 64'd100;
      scale = 64'd10000000;
      tol   = 64'd1759;
    endfunction

    function void write_reg(bit [1:0] idx, bit [63:0] val);
      if (idx == rlvb_pkg::REG_THRESHOLD) thr_c = val & 64'hF_FFFF;
      else if (idx == rlvb_pkg::REG_SCALE) scale = val & 64'h7FF_FFFF;
      else if (idx == rlvb_pkg::REG_TOLERANCE) tol = val & 64'h1FF_FFFF_FFFF;
    endfunction

    // saturating fixed-point product
    function bit [63:0] fmul(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:64+rlvb_pkg::FRAC_BITS] != 0) return ONES64;
      return p[64+rlvb_pkg::FRAC_BITS-1:rlvb_pkg::FRAC_BITS];
    endfunction

    // (a << FRAC_BITS) / d, saturating
    function bit [63:0] fdiv(bit [63:0] a, bit [63:0] d);
      bit [127:0] n;
      bit [127:0] q;
      if (d == 0) return ONES64;
      n = {64'd0, a} << rlvb_pkg::FRAC_BITS;
      q = n / {64'd0, d};
      if (q[127:64] != 0) return ONES64;
      return q[63:0];
    endfunction

    // floor cube root of u * 2^(2*FRAC_BITS)
    function bit [63:0] fcbrt(bit [63:0] u);
      bit [191:0] target;
      bit [191:0] c3;
      bit [63:0]  y;
      bit [63:0]  cand;
      target = {128'd0, u} << (2 * rlvb_pkg::FRAC_BITS);
      y = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = y | (64'd1 << b);
        c3 = {128'd0, cand} * {128'd0, cand} * {128'd0, cand};
        if (c3 <= target) y = cand;
      end
      return y;
    endfunction

    // sign of L*cbrt(1+ramp(S*x/L^3-C)) - x
    function int visc_sign(bit [63:0] lam, bit [63:0] sgs, bit [63:0] x);
      bit [63:0] l3, t, cq, r, u, p;
      l3 = fmul(fmul(lam, lam), lam);
      t  = fdiv(fmul(sgs, x), l3);
      cq = (thr_c >= (64'd1 << (64 - rlvb_pkg::FRAC_BITS))) ? ONES64 :
           (thr_c << rlvb_pkg::FRAC_BITS);
      r  = (t > cq) ? t - cq : 0;
      u  = r + UNIT;
      if (u < r) u = ONES64;
      p  = fmul(lam, fcbrt(u));
      if (p > x) return 1;
      if (p < x) return -1;
      return 0;
    endfunction

    function bit [63:0] mid(bit [63:0] a, bit [63:0] b);
      return (a >> 1) + (b >> 1) + {63'd0, a[0] & b[0]};
    endfunction

    function bit flips(int a, int b);
      return a != 0 && b != 0 && a != b;
    endfunction

    // accepted input: bisect and queue the expected result
    function void note_input(bit [63:0] lam, bit [63:0] sgs);
      bit [127:0] up;
      bit [63:0]  lo, hi, m;
      bit         fb;
      int         n, sa, sb, sm;
      up = {64'd0, scale} * {64'd0, ((sgs > lam) ? sgs : lam)};
      lo = lam;
      hi = (up[127:64] != 0) ? ONES64 : up[63:0];
      fb = 0;
      n  = 0;
      while (n < rlvb_pkg::MAX_STEPS && ((lo > hi) ? lo - hi : hi - lo) > tol) begin
        sa = visc_sign(lam, sgs, lo);
        sb = visc_sign(lam, sgs, hi);
        m  = mid(lo, hi);
        sm = visc_sign(lam, sgs, m);
        if (flips(sa, sm)) hi = m;
        else if (flips(sb, sm)) lo = m;
        else begin
          lo = lam;
          hi = lam;
          fb = 1;
          break;
        end
        n++;
      end
      expected_q.push_back({fb, mid(lo, hi)});
    endfunction

    function void check_result(bit [63:0] visc, bit fb);
      bit [64:0] e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result visc=%h fallback=%b", visc, fb);
        return;
      end
      e = expected_q.pop_front();
      if (e[63:0] !== visc || e[64] !== fb) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: visc exp %h got %h, fallback exp %b got %b",
                   e[63:0], visc, e[64], fb);
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic [rlvb_pkg::WORD_W-1:0]       laminar_visc = '0;
  logic [rlvb_pkg::WORD_W-1:0]       subgrid_visc = '0;
  logic                              busy;
  logic                              done;
  logic [rlvb_pkg::WORD_W-1:0]       effective_visc;
  logic                              fallback;
  logic                              cfg_we = 1'b0;
  logic [rlvb_pkg::IDX_W-1:0]        cfg_idx = '0;
  logic [rlvb_pkg::CFG_W-1:0]        cfg_data = '0;

  visc_scoreboard sb = new();

  always #5 clk = ~clk;

  rng_les_viscosity_bisection_unit u_dut (
    .clk(clk), .rst(rst), .start(start),
    .laminar_visc(laminar_visc), .subgrid_visc(subgrid_visc),
    .busy(busy), .done(done), .effective_visc(effective_visc), .fallback(fallback),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // results sampled mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (!rst && done) sb.check_result(effective_visc, fallback);
  end

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random gap: mostly none or short, now and then long
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    if (r < 94) repeat ($urandom_range(1, 6)) @(posedge clk);
    else repeat ($urandom_range(20, 200)) @(posedge clk);
  endtask

  task automatic write_reg(logic [rlvb_pkg::IDX_W-1:0] idx, bit [63:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[rlvb_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, 64'(val[rlvb_pkg::CFG_W-1:0]));
  endtask

  task automatic set_regs(bit [63:0] thr, bit [63:0] scl, bit [63:0] tl);
    write_reg(rlvb_pkg::REG_THRESHOLD, thr);
    write_reg(rlvb_pkg::REG_SCALE, scl);
    write_reg(rlvb_pkg::REG_TOLERANCE, tl);
  endtask

  // one command transfer
  task automatic send_item(bit [63:0] lam, bit [63:0] sgs);
    @(posedge clk);
    start        <= 1'b1;
    laminar_visc <= lam;
    subgrid_visc <= sgs;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sb.note_input(lam, sgs);
    start <= 1'b0;
    idle_gap();
  endtask

  // wait until every queued result has come back
  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random operand: mostly near unity, sometimes across the whole word
  function automatic bit [63:0] rand_visc();
    bit [63:0] v;
    if ($urandom_range(0, 9) == 0) v = rand64();
    else v = rand64() >> $urandom_range(18, 34);
    return v;
  endfunction

  initial begin
    bit [63:0] lam, sgs;
    sb.reset_regs();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: tiny L, huge L, no subgrid term, large subgrid term
    send_item(UNIT, 64'd0);
    send_item(64'd1, 64'd1);
    send_item(ONES64, ONES64);
    send_item(UNIT, UNIT << 6);
    drain();

    // upper end below L, zero threshold, widest tolerance
    set_regs(64'd0, 64'd0, 64'h1FF_FFFF_FFFF);
    send_item(UNIT, UNIT);
    send_item(ONES64, 64'd0);
    send_item(64'd1, ONES64);
    drain();

    // largest threshold and scale
    set_regs(64'hF_FFFF, 64'h7FF_FFFF, 64'd1 << 40);
    send_item(UNIT, UNIT);
    send_item(UNIT >> 4, ONES64);
    send_item(ONES64, 64'd1);
    send_item(64'd1, 64'd0);
    drain();

    // zero tolerance: step limit / exact convergence
    set_regs(64'd0, 64'd2, 64'd0);
    send_item(UNIT, UNIT << 8);
    drain();
    // tolerance one, bracket already within tolerance, unmapped index
    set_regs(64'd5, 64'd1, 64'd1);
    send_item(UNIT, UNIT >> 1);
    drain();
    write_reg(REG_SPARE, 64'h1FF_FFFF_FFFF);
    send_item(UNIT << 3, UNIT);
    drain();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 2))
        0: write_reg(rlvb_pkg::REG_THRESHOLD, 64'd0);
        1: write_reg(rlvb_pkg::REG_THRESHOLD, 64'($urandom_range(1, 200)));
        default: write_reg(rlvb_pkg::REG_THRESHOLD, 64'($urandom_range(0, 20'hF_FFFF)));
      endcase
      write_reg(rlvb_pkg::REG_SCALE, ($urandom_range(0, 7) == 0) ?
                64'($urandom_range(1, 27'h7FF_FFFF)) : 64'($urandom_range(1, 64)));
      write_reg(rlvb_pkg::REG_TOLERANCE, {$urandom_range(16, 511), 32'($urandom())});
      for (int i = 0; i < 45; i++) begin
        lam = rand_visc();
        if (lam == 0) lam = 64'd1;
        sgs = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_visc();
        send_item(lam, sgs);
      end
      drain();
    end

    if (sb.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // run limit
  initial begin
    #(64'd900_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
